### hdl/ftm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants for the fuzzy template search unit.
// ----------------------------------------------------------------------------
package ftm_pkg;
    localparam int MAX_IW = 512;
    localparam int MAX_IH = 512;
    localparam int MAX_TW = 64;
    localparam int MAX_TH = 64;
    localparam int IMG_AW = $clog2(MAX_IW * MAX_IH);
    localparam int TPL_AW = $clog2(MAX_TW * MAX_TH);
    localparam int IXW = $clog2(MAX_IW);
    localparam int IYW = $clog2(MAX_IH);
    localparam int TXW = $clog2(MAX_TW);
    localparam int TYW = $clog2(MAX_TH);
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        CMD_IMG    = 2'd0,
        CMD_TPL    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [2:0] REG_IW = 3'd0;
    localparam logic [2:0] REG_IH = 3'd1;
    localparam logic [2:0] REG_TW = 3'd2;
    localparam logic [2:0] REG_TH = 3'd3;
    localparam logic [2:0] REG_FUZZ = 3'd4;
    localparam logic [2:0] REG_PCT = 3'd5;

    // one queued item after classification
    typedef struct packed {
        t_cmd       cmd;
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] v;
    } t_item;

    typedef struct packed {
        logic [9:0] iw;
        logic [9:0] ih;
        logic [6:0] tw;
        logic [6:0] th;
        logic [7:0] fuzz;
        logic [6:0] pct;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

### hdl/ftm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_front
// Accepts input items, drops unknown commands and queues the rest.
// ----------------------------------------------------------------------------
module ftm_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire ftm_pkg::t_item i_item,
    output logic              o_valid,
    input  wire               i_pop,
    output ftm_pkg::t_item    o_item
);
    ftm_pkg::t_item r_q [ftm_pkg::QDEPTH];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'(ftm_pkg::QDEPTH));
    assign w_push  = i_valid && o_ready && (i_item.cmd != ftm_pkg::CMD_NONE);
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= i_item;
                r_wr <= ~r_wr;
            end
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

### hdl/ftm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_back
// Holds image and template stores and runs the offset search.
// ----------------------------------------------------------------------------
module ftm_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire ftm_pkg::t_cfg  i_cfg,
    input  wire               i_valid,
    input  wire ftm_pkg::t_item i_item,
    output logic              o_pop,
    output logic              o_res_valid,
    input  wire               i_res_ready,
    output logic [18:0]       o_res
);
    logic [7:0] r_img [2**ftm_pkg::IMG_AW];
    logic [7:0] r_tpl [2**ftm_pkg::TPL_AW];

    ftm_pkg::t_state r_st, n_st;
    logic [9:0] r_iw, r_ih;
    logic [6:0] r_tw, r_th, r_need;
    logic [8:0] r_ox, r_oy;
    logic [6:0] r_k, r_r, r_cnt;
    logic [7:0] r_a, r_b;
    logic       r_rv;
    logic [18:0] r_res;
    logic [18:0] r_sres;

    logic [9:0]  w_iw, w_ih;
    logic [6:0]  w_tw, w_th;
    logic [13:0] w_prod;
    logic [26:0] w_scaled;
    logic [6:0]  w_need;
    logic [8:0]  w_d;
    logic        w_hit;
    logic [6:0]  w_cnt1;
    logic        w_rowok, w_rowbad;
    logic        w_rowend, w_found, w_none;
    logic        w_xlast, w_ylast;
    logic [9:0]  w_iy;
    logic [9:0]  w_ix;

    assign w_iw = (i_cfg.iw > 10'(ftm_pkg::MAX_IW)) ? 10'(ftm_pkg::MAX_IW) : i_cfg.iw;
    assign w_ih = (i_cfg.ih > 10'(ftm_pkg::MAX_IH)) ? 10'(ftm_pkg::MAX_IH) : i_cfg.ih;
    assign w_tw = (i_cfg.tw > 7'(ftm_pkg::MAX_TW)) ? 7'(ftm_pkg::MAX_TW) : i_cfg.tw;
    assign w_th = (i_cfg.th > 7'(ftm_pkg::MAX_TH)) ? 7'(ftm_pkg::MAX_TH) : i_cfg.th;
    // percent * width / 100 as a multiply by 5243 / 2^19, exact below 8192
    assign w_prod   = 14'(i_cfg.pct) * 14'(w_tw);
    assign w_scaled = 27'(w_prod) * 27'd5243;
    assign w_need   = w_scaled[25:19];

    assign w_d    = (r_a > r_b) ? 9'(r_a - r_b) : 9'(r_b - r_a);
    assign w_hit  = (w_d <= {1'b0, i_cfg.fuzz});
    assign w_cnt1 = r_cnt + {6'd0, w_hit};
    assign w_rowok  = (r_need == 7'd0) || (w_cnt1 >= r_need);
    // remaining pixels cannot reach the need
    assign w_rowbad = (8'(w_cnt1) + 8'(r_tw - r_k - 7'd1)) < 8'(r_need);
    assign w_rowend = w_rowok || w_rowbad || (r_k == r_tw - 7'd1);
    assign w_found  = w_rowend && w_rowok && (r_r == r_th - 7'd1);
    assign w_xlast  = (10'(r_ox) == r_iw - 10'(r_tw));
    assign w_ylast  = (10'(r_oy) == r_ih - 10'(r_th));
    assign w_none   = w_rowend && !w_rowok && w_xlast && w_ylast;
    assign w_iy = 10'(r_oy) + 10'(r_r);
    assign w_ix = 10'(r_ox) + 10'(r_k);

    assign o_res_valid = r_rv;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_pop && i_item.cmd == ftm_pkg::CMD_IMG
            && 10'(i_item.x) < 10'(ftm_pkg::MAX_IW) && 10'(i_item.y) < 10'(ftm_pkg::MAX_IH))
            r_img[{i_item.y[ftm_pkg::IYW-1:0], i_item.x[ftm_pkg::IXW-1:0]}] <= i_item.v;
        if (i_valid && o_pop && i_item.cmd == ftm_pkg::CMD_TPL
            && i_item.x < 9'(ftm_pkg::MAX_TW) && i_item.y < 9'(ftm_pkg::MAX_TH))
            r_tpl[{i_item.y[ftm_pkg::TYW-1:0], i_item.x[ftm_pkg::TXW-1:0]}] <= i_item.v;
        r_a <= r_img[{w_iy[ftm_pkg::IYW-1:0], w_ix[ftm_pkg::IXW-1:0]}];
        r_b <= r_tpl[{r_r[ftm_pkg::TYW-1:0], r_k[ftm_pkg::TXW-1:0]}];
    end

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        case (r_st)
            ftm_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_item.cmd == ftm_pkg::CMD_SEARCH) n_st = ftm_pkg::S_SETUP;
                end
            end
            ftm_pkg::S_SETUP: begin
                if (w_iw == 10'd0 || w_ih == 10'd0 || w_tw == 7'd0 || w_th == 7'd0
                    || 10'(w_tw) > w_iw || 10'(w_th) > w_ih || w_need > w_tw)
                    n_st = ftm_pkg::S_DONE;
                else
                    n_st = ftm_pkg::S_READ;
            end
            ftm_pkg::S_READ: n_st = ftm_pkg::S_CMP;
            ftm_pkg::S_CMP: begin
                if (w_found || w_none) n_st = ftm_pkg::S_DONE;
                else n_st = ftm_pkg::S_READ;
            end
            ftm_pkg::S_DONE: if (!r_rv || i_res_ready) n_st = ftm_pkg::S_IDLE;
            default: n_st = ftm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ftm_pkg::S_IDLE;
            r_rv <= 1'b0;
        end else begin
            r_st <= n_st;
            // output register is loaded only once the previous result has left
            if (r_st == ftm_pkg::S_DONE && (!r_rv || i_res_ready)) begin
                r_res <= r_sres;
                r_rv  <= 1'b1;
            end else if (r_rv && i_res_ready) begin
                r_rv <= 1'b0;
            end
            case (r_st)
                ftm_pkg::S_SETUP: begin
                    r_iw <= w_iw; r_ih <= w_ih; r_tw <= w_tw; r_th <= w_th;
                    r_need <= w_need;
                    r_ox <= '0; r_oy <= '0; r_k <= '0; r_r <= '0; r_cnt <= '0;
                    r_sres <= '0;
                end
                ftm_pkg::S_CMP: begin
                    if (w_rowend) begin
                        r_k <= '0;
                        r_cnt <= '0;
                        if (w_found) begin
                            r_sres <= {r_oy, r_ox, 1'b1};
                        end else if (w_rowok) begin
                            r_r <= r_r + 7'd1;
                        end else begin
                            r_r <= '0;
                            if (w_xlast) begin
                                r_ox <= '0;
                                if (w_ylast) r_sres <= '0;
                                else r_oy <= r_oy + 9'd1;
                            end else r_ox <= r_ox + 9'd1;
                        end
                    end else begin
                        r_k <= r_k + 7'd1;
                        r_cnt <= w_cnt1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/fuzzy_template_match_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_template_match_search_unit
// Image/template loader and first-offset fuzzy template search.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   cmd, pixel_x, pixel_y, pixel_value
// m_axis    out  found, match_x, match_y
// cfg       in   index 0..5, 10-bit data
// Pixel writes pass through a two-entry queue.
// A search alternates a store read and a compare for each compared pixel,
// walking offsets with early row exit.
// Reset clears control only; stores are undefined until written.
// Input stalls once the queue is full while a search runs or a finished
// result waits for the receiver.
module fuzzy_template_match_search_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // pixel_x, pixel_y, pixel_value, zeros
    input  wire [1:0]   s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // found, match_x, match_y, zeros
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_index,
    input  wire [9:0]   i_cfg_data
);
    ftm_pkg::t_cfg  r_cfg;
    ftm_pkg::t_item w_in, w_q;
    logic w_qv, w_pop;
    logic [18:0] w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= {10'd512, 10'd512, 7'd64, 7'd64, 8'd0, 7'd100};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ftm_pkg::REG_IW:   r_cfg.iw <= i_cfg_data;
                ftm_pkg::REG_IH:   r_cfg.ih <= i_cfg_data;
                ftm_pkg::REG_TW:   r_cfg.tw <= i_cfg_data[6:0];
                ftm_pkg::REG_TH:   r_cfg.th <= i_cfg_data[6:0];
                ftm_pkg::REG_FUZZ: r_cfg.fuzz <= i_cfg_data[7:0];
                ftm_pkg::REG_PCT:  r_cfg.pct <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_in.cmd = ftm_pkg::t_cmd'(s_axis_tuser);
    assign w_in.x = s_axis_tdata[8:0];
    assign w_in.y = s_axis_tdata[17:9];
    assign w_in.v = s_axis_tdata[25:18];

    ftm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_pop(w_pop), .o_item(w_q)
    );

    ftm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_qv), .i_item(w_q), .o_pop(w_pop),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res};
endmodule
`default_nettype wire

### tb/fuzzy_template_match_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_template_match_search_unit_tb
// Loads images and templates, runs searches over many register settings and
// checks every search result against a behavioral match finder or a directed expected value.
// ----------------------------------------------------------------------------
module fuzzy_template_match_search_unit_tb;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic       found;
        logic [8:0] mx;
        logic [8:0] my;
    } t_hit;

    typedef struct {
        ftm_pkg::t_cmd cmd;
        int   x;
        int   y;
        int   v;
        bit   chk;
        t_hit hit;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    fuzzy_template_match_search_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // mirror of the block's stores and registers
    logic [7:0] img_mem [0:ftm_pkg::MAX_IW*ftm_pkg::MAX_IH-1];
    logic [7:0] tpl_mem [0:ftm_pkg::MAX_TW*ftm_pkg::MAX_TH-1];
    bit         img_wr  [0:ftm_pkg::MAX_IW*ftm_pkg::MAX_IH-1];
    bit         tpl_wr  [0:ftm_pkg::MAX_TW*ftm_pkg::MAX_TH-1];
    int         iw_r, ih_r, tw_r, th_r, fuzz_r, pct_r;

    t_hit pending_hits [$];
    int   mismatches = 0;
    int   hold_req = 0;
    bit   no_gaps = 1'b0;
    int   random_sent = 0;

    t_row dir_tab [0:13] = '{
        '{ftm_pkg::CMD_IMG,    0,   0,   255, 1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_IMG,    511, 511, 0,   1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_TPL,    63,  63,  255, 1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_TPL,    511, 0,   7,   1'b0, '{1'b0, 9'd0, 9'd0}},  // out of store
        '{ftm_pkg::CMD_TPL,    0,   511, 7,   1'b0, '{1'b0, 9'd0, 9'd0}},  // out of store
        '{ftm_pkg::CMD_NONE,   511, 511, 255, 1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_SEARCH, 0,   0,   0,   1'b1, '{1'b1, 9'd1, 9'd0}},
        '{ftm_pkg::CMD_TPL,    0,   0,   255, 1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_SEARCH, 511, 511, 255, 1'b1, '{1'b1, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_IMG,    0,   0,   0,   1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_SEARCH, 0,   0,   0,   1'b1, '{1'b0, 9'd0, 9'd0}},  // no match
        '{ftm_pkg::CMD_IMG,    2,   1,   255, 1'b0, '{1'b0, 9'd0, 9'd0}},
        '{ftm_pkg::CMD_SEARCH, 0,   0,   0,   1'b1, '{1'b1, 9'd2, 9'd1}},
        '{ftm_pkg::CMD_NONE,   0,   0,   0,   1'b0, '{1'b0, 9'd0, 9'd0}}
    };

    function automatic int clampi(int v, int m);
        return (v > m) ? m : v;
    endfunction

    function automatic t_hit find_match();
        t_hit h;
        int   iw, ih, tw, th, need, cnt, d;
        bit   ok;
        h = '0;
        iw = clampi(iw_r, ftm_pkg::MAX_IW);
        ih = clampi(ih_r, ftm_pkg::MAX_IH);
        tw = clampi(tw_r, ftm_pkg::MAX_TW);
        th = clampi(th_r, ftm_pkg::MAX_TH);
        if (iw == 0 || ih == 0 || tw == 0 || th == 0) return h;
        if (tw > iw || th > ih) return h;
        need = pct_r * tw / 100;
        if (need > tw) return h;
        for (int y = 0; y <= ih - th; y++) begin
            for (int x = 0; x <= iw - tw; x++) begin
                ok = 1'b1;
                for (int r = 0; r < th && ok; r++) begin
                    cnt = 0;
                    for (int k = 0; k < tw; k++) begin
                        d = int'(img_mem[(y + r) * ftm_pkg::MAX_IW + x + k])
                            - int'(tpl_mem[r * ftm_pkg::MAX_TW + k]);
                        if (d < 0) d = -d;
                        if (d <= fuzz_r) cnt++;
                    end
                    if (cnt < need) ok = 1'b0;
                end
                if (ok) begin
                    h.found = 1'b1;
                    h.mx = x[8:0];
                    h.my = y[8:0];
                    return h;
                end
            end
        end
        return h;
    endfunction

    // update the mirror for one accepted item; searches queue their hit
    function automatic void absorb_item(ftm_pkg::t_cmd cmd, int x, int y, int v, bit chk,
                                        t_hit hit);
        case (cmd)
            ftm_pkg::CMD_IMG: begin
                img_mem[y * ftm_pkg::MAX_IW + x] = v[7:0];
                img_wr[y * ftm_pkg::MAX_IW + x] = 1'b1;
            end
            ftm_pkg::CMD_TPL: begin
                if (x < ftm_pkg::MAX_TW && y < ftm_pkg::MAX_TH) begin
                    tpl_mem[y * ftm_pkg::MAX_TW + x] = v[7:0];
                    tpl_wr[y * ftm_pkg::MAX_TW + x] = 1'b1;
                end
            end
            ftm_pkg::CMD_SEARCH: pending_hits.push_back(chk ? hit : find_match());
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(ftm_pkg::t_cmd cmd, int x, int y, int v, bit chk = 1'b0,
                             t_hit hit = '0);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, v[7:0], y[8:0], x[8:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_item(cmd, x, y, v, chk, hit);
    endtask

    // sender pauses until every search has answered, then lets the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[9:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ftm_pkg::REG_IW:   iw_r = val & 10'h3FF;
            ftm_pkg::REG_IH:   ih_r = val & 10'h3FF;
            ftm_pkg::REG_TW:   tw_r = val & 7'h7F;
            ftm_pkg::REG_TH:   th_r = val & 7'h7F;
            ftm_pkg::REG_FUZZ: fuzz_r = val & 8'hFF;
            ftm_pkg::REG_PCT:  pct_r = val & 7'h7F;
            default: ;
        endcase
    endtask

    task automatic set_cfg(int iw, int ih, int tw, int th, int fz, int pc);
        write_reg(ftm_pkg::REG_IW, iw);
        write_reg(ftm_pkg::REG_IH, ih);
        write_reg(ftm_pkg::REG_TW, tw);
        write_reg(ftm_pkg::REG_TH, th);
        write_reg(ftm_pkg::REG_FUZZ, fz);
        write_reg(ftm_pkg::REG_PCT, pc);
    endtask

    // write every pixel a search could read that has not been written yet
    task automatic fill_unwritten(int val);
        int iw, ih, tw, th;
        iw = clampi(iw_r, ftm_pkg::MAX_IW);
        ih = clampi(ih_r, ftm_pkg::MAX_IH);
        tw = clampi(tw_r, ftm_pkg::MAX_TW);
        th = clampi(th_r, ftm_pkg::MAX_TH);
        for (int y = 0; y < ih; y++)
            for (int x = 0; x < iw; x++)
                if (!img_wr[y * ftm_pkg::MAX_IW + x])
                    send_item(ftm_pkg::CMD_IMG, x, y,
                              (val < 0) ? $urandom_range(0, 255) : val);
        for (int y = 0; y < th; y++)
            for (int x = 0; x < tw; x++)
                if (!tpl_wr[y * ftm_pkg::MAX_TW + x])
                    send_item(ftm_pkg::CMD_TPL, x, y,
                              (val < 0) ? $urandom_range(0, 255) : val);
    endtask

    task automatic random_phase();
        int n, r, ox, oy, nv;
        // mostly small sizes, now and then a template that does not fit
        set_cfg($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 4),
                $urandom_range(1, 4),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24),
                ($urandom_range(0, 15) == 0) ? $urandom_range(101, 127) :
                                               $urandom_range(0, 100));
        fill_unwritten(-1);
        if ($urandom_range(0, 9) < 4 && tw_r <= iw_r && th_r <= ih_r) begin
            // copy the template into the image, with small noise
            ox = $urandom_range(0, iw_r - tw_r);
            oy = $urandom_range(0, ih_r - th_r);
            for (int y = 0; y < th_r; y++)
                for (int x = 0; x < tw_r; x++) begin
                    nv = int'(tpl_mem[y * ftm_pkg::MAX_TW + x]) + $urandom_range(0, 4) - 2;
                    nv = (nv < 0) ? 0 : (nv > 255) ? 255 : nv;
                    send_item(ftm_pkg::CMD_IMG, ox + x, oy + y, nv);
                    random_sent++;
                end
            send_item(ftm_pkg::CMD_SEARCH, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 255));
            random_sent++;
        end
        n = $urandom_range(10, 30);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(ftm_pkg::CMD_IMG, $urandom_range(0, iw_r - 1),
                          $urandom_range(0, ih_r - 1), $urandom_range(0, 255));
            else if (r < 62)
                send_item(ftm_pkg::CMD_TPL, $urandom_range(0, tw_r - 1),
                          $urandom_range(0, th_r - 1), $urandom_range(0, 255));
            else if (r < 80)
                send_item(ftm_pkg::CMD_SEARCH, $urandom_range(0, 511),
                          $urandom_range(0, 511), $urandom_range(0, 255));
            else if (r < 90)
                send_item(ftm_pkg::CMD_IMG, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 255));
            else if (r < 96)
                send_item(ftm_pkg::CMD_TPL, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 255));
            else
                send_item(ftm_pkg::CMD_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 255));
            random_sent++;
        end
        drain();
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin : result_sink
        int   stall;
        int   seen_req;
        t_hit got, want;
        stall = 0;
        seen_req = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tdata[0];
                got.mx = m_axis_tdata[9:1];
                got.my = m_axis_tdata[18:10];
                if (pending_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result found=%0d x=%0d y=%0d",
                                 got.found, got.mx, got.my);
                end else begin
                    want = pending_hits.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp found=%0d x=%0d y=%0d, ",
                                      "got found=%0d x=%0d y=%0d"},
                                     want.found, want.mx, want.my,
                                     got.found, got.mx, got.my);
                    end
                end
            end
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                stall = 400;
            end else if (stall == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we)
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("FAIL fuzzy_template_match_search_unit");
                $finish;
            end
        end
    end

    initial begin : stimulus
        iw_r = 512; ih_r = 512; tw_r = 64; th_r = 64; fuzz_r = 0; pct_r = 100;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_cfg(4, 3, 2, 2, 0, 100);
        fill_unwritten(0);
        foreach (dir_tab[i])
            send_item(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, dir_tab[i].v,
                      dir_tab[i].chk, dir_tab[i].hit);
        drain();

        // loose tolerance: everything matches at the first offset
        write_reg(ftm_pkg::REG_FUZZ, 255);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0, 1'b1, '{1'b1, 9'd0, 9'd0});
        drain();

        // full queue while the receiver holds off
        hold_req++;
        no_gaps = 1'b1;
        repeat (6) send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0);
        no_gaps = 1'b0;
        drain();

        // wide image, widest template (oversized widths saturate)
        set_cfg(1023, 1, 127, 1, $urandom_range(0, 40), 50);
        fill_unwritten(-1);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0);
        drain();
        write_reg(ftm_pkg::REG_PCT, 0);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0);
        drain();
        // tall image, tallest template (oversized height saturates)
        set_cfg(1, 70, 1, 127, 255, 100);
        fill_unwritten(-1);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0);
        drain();
        // zero sizes, template larger than image, percent above one hundred
        set_cfg(0, 4, 1, 1, 0, 100);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0, 1'b1, '{1'b0, 9'd0, 9'd0});
        drain();
        set_cfg(4, 4, 0, 1, 0, 100);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0, 1'b1, '{1'b0, 9'd0, 9'd0});
        drain();
        set_cfg(3, 3, 4, 2, 255, 100);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0, 1'b1, '{1'b0, 9'd0, 9'd0});
        drain();
        set_cfg(4, 4, 4, 1, 255, 127);
        send_item(ftm_pkg::CMD_SEARCH, 0, 0, 0, 1'b1, '{1'b0, 9'd0, 9'd0});
        drain();

        while (random_sent < RANDOM_ITEMS) random_phase();

        drain();
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("PASS fuzzy_template_match_search_unit");
        end else begin
            $display("FAIL fuzzy_template_match_search_unit");
        end
        $finish;
    end
endmodule
